/* hw/rtl/dss_pkg.sv */
// ============================================================================
// dss_pkg
// Shared types and constants for the delimiter string splitter.
// ============================================================================
package dss_pkg;

    // Window depth: the longest delimiter that can be matched.
    localparam int MAX_DELIM = 8;

    // Width of the internal position counters.
    localparam int POS_BITS = 16;

    // Fixed field widths.
    localparam int CHAR_BITS     = 16;
    localparam int SEG_BITS      = 16;
    localparam int LEN_BITS      = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    // Eight delimiter characters are held in the two character registers.
    localparam int DELIM_SLOTS     = 8;
    localparam int DELIM_SEL_BITS  = 3;
    localparam int CHARS_PER_REG   = CFG_DATA_BITS / CHAR_BITS;

    // The run counter saturates at MAX_DELIM + 1.
    localparam int RUN_BITS = $clog2(MAX_DELIM + 2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_DELIM_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELIM_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELIM_LEN  = 2'd2;

    // Input word: one character of the string.
    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 char_last;
    } char_word_t;

    // Output word: one segment.
    typedef struct packed {
        logic [SEG_BITS-1:0] seg_start;
        logic [SEG_BITS-1:0] seg_end;
        logic                seg_final;
    } seg_word_t;

endpackage

/* hw/rtl/dss_cell.sv */
// ============================================================================
// dss_cell
// One window cell: holds a character, passes it on and checks the incoming
// character against its delimiter character.
// ============================================================================
module dss_cell
(
    input  logic                         clk,
    input  logic                         shift,
    input  logic [dss_pkg::CHAR_BITS-1:0] char_in,
    input  logic [dss_pkg::CHAR_BITS-1:0] ref_char,
    input  logic                         active,
    output logic [dss_pkg::CHAR_BITS-1:0] char_out,
    output logic                         hit
);
    import dss_pkg::*;

    logic [CHAR_BITS-1:0] char_reg;

    // The character shifts in from the neighbor on every accepted word.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            char_reg <= char_in;
        end
    end

    assign char_out = char_reg;

    // The compare looks at the value this cell takes on the current shift.
    // A cell beyond the delimiter length always agrees.
    assign hit = !active || (char_in == ref_char);

endmodule

/* hw/rtl/dss_ctrl.sv */
// ============================================================================
// dss_ctrl
// Segment tracking and output staging for the delimiter string splitter.
// ============================================================================
module dss_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_accept,
    input  logic                         char_last,
    input  logic [dss_pkg::LEN_BITS-1:0] len_eff,
    input  logic                         all_hit,
    input  logic                         out_stall,
    output logic                         in_stall,
    output logic                         out_valid,
    output dss_pkg::seg_word_t           out_word
);
    import dss_pkg::*;

    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic [POS_BITS-1:0] begin_reg;
    logic [POS_BITS-1:0] begin_next;
    logic [RUN_BITS-1:0] run_reg;
    logic [RUN_BITS-1:0] run_next;
    logic [RUN_BITS-1:0] run_inc;

    logic                out_valid_reg;
    logic                out_valid_next;
    seg_word_t           out_reg;
    seg_word_t           out_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    seg_word_t           skid_reg;
    seg_word_t           skid_next;

    logic                matched;
    logic                emit;
    logic [POS_BITS-1:0] end_pos;
    seg_word_t           result;
    logic                take;
    logic                produce;

    // Run length including the character being taken, saturating.
    assign run_inc = (run_reg <= RUN_BITS'(MAX_DELIM)) ? run_reg + 1'b1 : run_reg;

    // A delimiter ends here when all cells agree and enough characters of
    // the open run lie in the window.
    assign matched = (len_eff != '0) && (run_inc >= RUN_BITS'(len_eff)) && all_hit;

    // A match with characters before it, or the end of the string, closes
    // a nonempty segment.
    assign emit = matched ? (run_inc > RUN_BITS'(len_eff)) : char_last;

    assign end_pos = matched ? pos_reg - POS_BITS'(len_eff) : pos_reg;

    always_comb
    begin
        result.seg_start = SEG_BITS'(begin_reg);
        result.seg_end   = SEG_BITS'(end_pos);
        result.seg_final = char_last;
    end

    // Position, segment start and run length for the next character.
    always_comb
    begin
        pos_next   = pos_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        if (in_accept)
        begin
            if (char_last)
            begin
                pos_next   = '0;
                begin_next = '0;
                run_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (matched)
                begin
                    begin_next = pos_reg + 1'b1;
                    run_next   = '0;
                end
                else
                begin
                    run_next = run_inc;
                end
            end
        end
    end

    // Output register with a skid word behind it.
    assign take    = out_valid_reg && !out_stall;
    assign produce = in_accept && emit;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (produce)
            begin
                out_next = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            begin_reg      <= '0;
            run_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            begin_reg      <= begin_next;
            run_reg        <= run_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Output words.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

/* hw/rtl/delimiter_string_splitter.sv */
// ============================================================================
// delimiter_string_splitter
// Splits a string of 16-bit characters on a configured delimiter.
// ============================================================================
// Usage:
//   The input channel takes one character word per cycle (in_valid/in_stall),
//   char_last marking the final character of a string. The output channel
//   gives one word per segment (out_valid/out_stall): the start and end
//   positions of a nonempty segment, and seg_final if closed by the last character.
//   Positions count from zero in every string.
//   A character is matched in the cycle it is taken by a row of window cells
//   that compare in parallel; its segment word, if any, is registered at the
//   output or in the skid register. Throughput is one character per cycle while
//   in_stall is low. When the receiver stalls, one more segment word is held in a
//   skid register; once that is full, in_stall rises until the receiver takes a
//   word. The delimiter (cfg index 0, 1: characters, 2: length) must be written
//   through the cfg port only while no string is in flight (not enforced). Reset
//   restores a one character delimiter of code zero and clears the tracking state.
// ============================================================================
module delimiter_string_splitter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [dss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dss_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dss_pkg::char_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dss_pkg::seg_word_t                out_word
);
    import dss_pkg::*;

    logic [CFG_DATA_BITS-1:0] delim_low_reg;
    logic [CFG_DATA_BITS-1:0] delim_high_reg;
    logic [LEN_BITS-1:0]      delim_len_reg;

    logic [CHAR_BITS-1:0]     delim_char [DELIM_SLOTS];
    logic [LEN_BITS-1:0]      len_eff;
    logic                     in_accept;
    logic [CHAR_BITS-1:0]     window [MAX_DELIM];
    logic [MAX_DELIM-1:0]     hit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_low_reg  <= '0;
            delim_high_reg <= '0;
            delim_len_reg  <= LEN_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DELIM_LOW:  delim_low_reg  <= cfg_data;
                REG_DELIM_HIGH: delim_high_reg <= cfg_data;
                REG_DELIM_LEN:  delim_len_reg  <= cfg_data[LEN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Delimiter characters as an array, character 0 first.
    always_comb
    begin
        for (int i = 0; i < CHARS_PER_REG; i++)
        begin
            delim_char[i]                 = delim_low_reg[i*CHAR_BITS +: CHAR_BITS];
            delim_char[i + CHARS_PER_REG] = delim_high_reg[i*CHAR_BITS +: CHAR_BITS];
        end
    end

    // Lengths above the window depth are clipped to it.
    assign len_eff = (delim_len_reg > LEN_BITS'(MAX_DELIM)) ? LEN_BITS'(MAX_DELIM)
                                                            : delim_len_reg;

    assign in_accept = in_valid && !in_stall;

    // Row of window cells, newest character in cell 0. Cell k lines up
    // with delimiter character len - 1 - k.
    for (genvar k = 0; k < MAX_DELIM; k++)
    begin : g_cell
        logic [LEN_BITS-1:0]  sel;
        logic [CHAR_BITS-1:0] cell_in;

        assign sel = len_eff - LEN_BITS'(k) - LEN_BITS'(1);

        if (k == 0)
        begin : g_head
            assign cell_in = in_word.char_code;
        end
        else
        begin : g_body
            assign cell_in = window[k-1];
        end

        dss_cell u_cell
        (
            .clk      (clk),
            .shift    (in_accept),
            .char_in  (cell_in),
            .ref_char (delim_char[sel[DELIM_SEL_BITS-1:0]]),
            .active   (LEN_BITS'(k) < len_eff),
            .char_out (window[k]),
            .hit      (hit[k])
        );
    end

    // Segment tracking and output staging.
    dss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .char_last (in_word.char_last),
        .len_eff   (len_eff),
        .all_hit   (&hit),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

/* hw/rtl/dss_checker.sv */
// ============================================================================
// dss_checker
// Port-level checks for the delimiter string splitter.
// ============================================================================
module dss_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  dss_pkg::seg_word_t                out_word
);
    import dss_pkg::*;

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // The input is only held off while a result waits at the output.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output word pending");

    // The skid only fills when the output was blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
        else $error("input stall rose without a blocked output");

    // A new output word always comes from an accepted character.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("output word appeared without an accepted character");

endmodule

bind delimiter_string_splitter dss_checker u_dss_checker (.*);
